>>> hdl/bemfnm_pkg.sv
`default_nettype none

package bemfnm_pkg;

   // signature geometry
   localparam int NumRefs   = 5;
   localparam int NumPoints = 6;
   localparam int NumPairs  = NumPoints / 2;
   localparam int NumHalf   = (NumRefs + 1) / 2;

   // datapath widths
   localparam int SampleW = 12;
   localparam int DiffW   = SampleW + 1;
   localparam int SqW     = 24;
   localparam int PairW   = SqW + 1;
   localparam int SumW    = 27;
   localparam int IdxW    = 3;
   localparam int ClassW  = 3;

   typedef logic signed [SampleW-1:0] sample_type;
   typedef sample_type signature_type [NumPoints];
   typedef logic [SumW-1:0] dist_type;
   typedef logic [IdxW-1:0] index_type;
   typedef logic [ClassW-1:0] class_type;

   // reference signatures, one row per reference
   localparam signature_type RefTable [NumRefs] = '{
      '{ 12'sd0,  -12'sd17,   -12'sd62,   -12'sd119,  -12'sd206,  -12'sd312},
      '{-12'sd4,  -12'sd35,   -12'sd393,  -12'sd1224, -12'sd1270, -12'sd1261},
      '{ 12'sd2,  -12'sd145,  -12'sd303,  -12'sd377,  -12'sd418,  -12'sd449},
      '{-12'sd5,  -12'sd23,   -12'sd304,  -12'sd1253, -12'sd1268, -12'sd1265},
      '{-12'sd6,  -12'sd41,   -12'sd1252, -12'sd1319, -12'sd1317, -12'sd1322}
   };

   // motor class code of each reference
   localparam class_type ClassTable [NumRefs] = '{3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

   // stage enables seen by every distance lane
   typedef struct packed {
      logic sq_en;
      logic pair_en;
      logic sum_en;
   } lane_ctl_type;

   // stage enables seen by the merge stage
   typedef struct packed {
      logic cmp_en;
      logic out_en;
   } merge_ctl_type;

endpackage

`default_nettype wire

>>> hdl/bemfnm_lane.sv
`default_nettype none

module bemfnm_lane (
   input  wire logic                     clock,
   input  bemfnm_pkg::signature_type     sample,
   input  bemfnm_pkg::signature_type     ref_sig,
   input  bemfnm_pkg::lane_ctl_type      ctl,
   output bemfnm_pkg::dist_type          err_sum
);

   logic signed [bemfnm_pkg::DiffW-1:0]   diff [bemfnm_pkg::NumPoints];
   logic signed [2*bemfnm_pkg::DiffW-1:0] prod [bemfnm_pkg::NumPoints];
   logic [bemfnm_pkg::SqW-1:0]   sq_in   [bemfnm_pkg::NumPoints];
   logic [bemfnm_pkg::SqW-1:0]   sq_ff   [bemfnm_pkg::NumPoints];
   logic [bemfnm_pkg::PairW-1:0] pair_in [bemfnm_pkg::NumPairs];
   logic [bemfnm_pkg::PairW-1:0] pair_ff [bemfnm_pkg::NumPairs];
   bemfnm_pkg::dist_type         dist_in;
   bemfnm_pkg::dist_type         dist_ff;

   // per point difference and square
   always_comb begin
      for (int p = 0; p < bemfnm_pkg::NumPoints; p++) begin
         diff[p]  = bemfnm_pkg::DiffW'(sample[p]) - bemfnm_pkg::DiffW'(ref_sig[p]);
         prod[p]  = diff[p] * diff[p];
         sq_in[p] = prod[p][bemfnm_pkg::SqW-1:0];
      end
   end

   // pairwise partial sums
   always_comb begin
      for (int j = 0; j < bemfnm_pkg::NumPairs; j++) begin
         pair_in[j] = bemfnm_pkg::PairW'(sq_ff[2*j]) + bemfnm_pkg::PairW'(sq_ff[2*j+1]);
      end
   end

   // lane total
   always_comb begin
      dist_in = '0;
      for (int j = 0; j < bemfnm_pkg::NumPairs; j++) begin
         dist_in = dist_in + bemfnm_pkg::SumW'(pair_ff[j]);
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (ctl.sq_en) begin
         sq_ff <= sq_in;
      end
      if (ctl.pair_en) begin
         pair_ff <= pair_in;
      end
      if (ctl.sum_en) begin
         dist_ff <= dist_in;
      end
   end

   assign err_sum = dist_ff;

endmodule

`default_nettype wire

>>> hdl/bemfnm_merge.sv
`default_nettype none

module bemfnm_merge (
   input  wire logic                 clock,
   input  bemfnm_pkg::dist_type      err_sum [bemfnm_pkg::NumRefs],
   input  bemfnm_pkg::merge_ctl_type ctl,
   output bemfnm_pkg::index_type     best_index,
   output bemfnm_pkg::class_type     class_code
);

   bemfnm_pkg::dist_type  half_dist_in [bemfnm_pkg::NumHalf];
   bemfnm_pkg::dist_type  half_dist_ff [bemfnm_pkg::NumHalf];
   bemfnm_pkg::index_type half_idx_in  [bemfnm_pkg::NumHalf];
   bemfnm_pkg::index_type half_idx_ff  [bemfnm_pkg::NumHalf];
   bemfnm_pkg::dist_type  win_dist;
   bemfnm_pkg::index_type win_idx;
   bemfnm_pkg::index_type best_index_ff;
   bemfnm_pkg::class_type class_code_ff;

   // first level: neighbor pairs, the lower index keeps ties
   always_comb begin
      for (int h = 0; h < bemfnm_pkg::NumHalf; h++) begin
         half_dist_in[h] = err_sum[2*h];
         half_idx_in[h]  = bemfnm_pkg::IdxW'(2*h);
         if (2*h + 1 < bemfnm_pkg::NumRefs) begin
            if (err_sum[2*h+1] < err_sum[2*h]) begin
               half_dist_in[h] = err_sum[2*h+1];
               half_idx_in[h]  = bemfnm_pkg::IdxW'(2*h + 1);
            end
         end
      end
   end

   // second level: scan the pair winners in index order
   always_comb begin
      win_dist = half_dist_ff[0];
      win_idx  = half_idx_ff[0];
      for (int h = 1; h < bemfnm_pkg::NumHalf; h++) begin
         if (half_dist_ff[h] < win_dist) begin
            win_dist = half_dist_ff[h];
            win_idx  = half_idx_ff[h];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         half_dist_ff <= half_dist_in;
         half_idx_ff  <= half_idx_in;
      end
      if (ctl.out_en) begin
         best_index_ff <= win_idx;
         class_code_ff <= bemfnm_pkg::ClassTable[win_idx];
      end
   end

   assign best_index = best_index_ff;
   assign class_code = class_code_ff;

endmodule

`default_nettype wire

>>> hdl/bemf_signature_nearest_match_unit.sv
// Nearest-match classifier for six-point back-EMF signatures. Each item
// carries six signed 12-bit samples; five lanes, one per constant reference
// signature, sum the squared differences, and a two-level compare picks the
// reference with the smallest sum (the lower index wins a tie). The result
// item gives that reference's index 0..4 and its motor class code 3..7.
// The pipeline takes one item per clock cycle unless req_stall is high; an
// item passes six registers on its way to the result: input register,
// square, pair sum, lane total, pair compare, final compare into
// the output register. Each stage holds only while the stage after it is
// full and held, so items keep entering while a result waits on rsp_stall
// as long as the pipeline has empty slots.

`default_nettype none

module bemf_signature_nearest_match_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [bemfnm_pkg::SampleW-1:0] req_sample_f0,
   input  wire logic signed [bemfnm_pkg::SampleW-1:0] req_sample_f1,
   input  wire logic signed [bemfnm_pkg::SampleW-1:0] req_sample_f2,
   input  wire logic signed [bemfnm_pkg::SampleW-1:0] req_sample_f3,
   input  wire logic signed [bemfnm_pkg::SampleW-1:0] req_sample_f4,
   input  wire logic signed [bemfnm_pkg::SampleW-1:0] req_sample_f5,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [bemfnm_pkg::IdxW-1:0]              rsp_best_index,
   output logic [bemfnm_pkg::ClassW-1:0]            rsp_class_code
);

   bemfnm_pkg::signature_type samples_ff;
   bemfnm_pkg::dist_type      err_sum [bemfnm_pkg::NumRefs];
   bemfnm_pkg::lane_ctl_type  lane_ctl;
   bemfnm_pkg::merge_ctl_type merge_ctl;

   logic v_in_ff, v_sq_ff, v_pair_ff, v_sum_ff, v_cmp_ff, v_out_ff;
   logic e_in, e_sq, e_pair, e_sum, e_cmp, e_out;

   // a stage advances when the next one is empty or advancing
   always_comb begin
      e_out  = !v_out_ff || !rsp_stall;
      e_cmp  = !v_cmp_ff || e_out;
      e_sum  = !v_sum_ff || e_cmp;
      e_pair = !v_pair_ff || e_sum;
      e_sq   = !v_sq_ff || e_pair;
      e_in   = !v_in_ff || e_sq;
   end

   always_comb begin
      lane_ctl.sq_en    = e_sq;
      lane_ctl.pair_en  = e_pair;
      lane_ctl.sum_en   = e_sum;
      merge_ctl.cmp_en  = e_cmp;
      merge_ctl.out_en  = e_out;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff   <= 1'b0;
         v_sq_ff   <= 1'b0;
         v_pair_ff <= 1'b0;
         v_sum_ff  <= 1'b0;
         v_cmp_ff  <= 1'b0;
         v_out_ff  <= 1'b0;
      end else begin
         if (e_in)   v_in_ff   <= req_valid;
         if (e_sq)   v_sq_ff   <= v_in_ff;
         if (e_pair) v_pair_ff <= v_sq_ff;
         if (e_sum)  v_sum_ff  <= v_pair_ff;
         if (e_cmp)  v_cmp_ff  <= v_sum_ff;
         if (e_out)  v_out_ff  <= v_cmp_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (e_in) begin
         samples_ff[0] <= req_sample_f0;
         samples_ff[1] <= req_sample_f1;
         samples_ff[2] <= req_sample_f2;
         samples_ff[3] <= req_sample_f3;
         samples_ff[4] <= req_sample_f4;
         samples_ff[5] <= req_sample_f5;
      end
   end

   // one distance lane per reference
   for (genvar r = 0; r < bemfnm_pkg::NumRefs; r++) begin : g_lane
      bemfnm_lane u_lane (
         .clock   (clock),
         .sample  (samples_ff),
         .ref_sig (bemfnm_pkg::RefTable[r]),
         .ctl     (lane_ctl),
         .err_sum (err_sum[r])
      );
   end

   // minimum search and output register
   bemfnm_merge u_merge (
      .clock      (clock),
      .err_sum    (err_sum),
      .ctl        (merge_ctl),
      .best_index (rsp_best_index),
      .class_code (rsp_class_code)
   );

   assign req_stall = !e_in;
   assign rsp_valid = v_out_ff;

endmodule

`default_nettype wire

>>> hdl/bemfnm_checker.sv
`default_nettype none

module bemfnm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [bemfnm_pkg::IdxW-1:0]   rsp_best_index,
   input wire logic [bemfnm_pkg::ClassW-1:0] rsp_class_code
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // index stays within the reference set
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_index < bemfnm_pkg::IdxW'(bemfnm_pkg::NumRefs)))
      else $error("best index out of range");

   // class code follows the index
   a_class_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_class_code == bemfnm_pkg::ClassW'(rsp_best_index + 3'd3)))
      else $error("class code does not match index");

   // an empty pipeline never stalls the input
   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !req_valid) ##1 (!rsp_valid && !req_valid) ##1
      (!rsp_valid && !req_valid) ##1 (!rsp_valid && !req_valid) ##1
      (!rsp_valid && !req_valid) ##1 (!rsp_valid && !req_valid) |-> !req_stall)
      else $error("input stalled while empty");

   // held result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_best_index)))
      else $error("held result changed");

endmodule

bind bemf_signature_nearest_match_unit bemfnm_checker u_bemfnm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_best_index (rsp_best_index),
   .rsp_class_code (rsp_class_code)
);

`default_nettype wire

>>> test/bemf_signature_nearest_match_unit_test.sv
`timescale 1ns / 100ps

module bemf_signature_nearest_match_unit_test;

   localparam longint ErrBound  = 64'h7FFFFFF;
   localparam int     HoldLong  = 80;
   localparam int     PhaseLen  = 300;
   localparam int     NumPhases = 4;
   localparam int     NumRefs   = bemfnm_pkg::NumRefs;
   localparam int     NumPoints = bemfnm_pkg::NumPoints;
   localparam int     SampleW   = bemfnm_pkg::SampleW;

   typedef struct {
      bemfnm_pkg::index_type idx;
      bemfnm_pkg::class_type cls;
   } match_type;

   // expected matches, predicted from each accepted signature
   class match_ledger;
      int                    sig [NumRefs][NumPoints];
      bemfnm_pkg::class_type motor_code [NumRefs];
      match_type             due_matches [$];
      int                    noted;
      int                    errors;

      function new();
         sig = '{
            '{ 0, -17,   -62,   -119,  -206,  -312},
            '{-4, -35,   -393,  -1224, -1270, -1261},
            '{ 2, -145,  -303,  -377,  -418,  -449},
            '{-5, -23,   -304,  -1253, -1268, -1265},
            '{-6, -41,   -1252, -1319, -1317, -1322}
         };
         motor_code = '{3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
         noted = 0;
         errors = 0;
      endfunction

      function int pending();
         return due_matches.size();
      endfunction

      // squared euclidean distance to each reference, smallest wins, earlier on a tie
      function void note_signature(input logic [NumPoints*SampleW-1:0] s);
         longint    best_sum;
         longint    sum;
         longint    d;
         int        best;
         match_type m;
         best_sum = ErrBound;
         best = 0;
         for (int r = 0; r < NumRefs; r++) begin
            sum = 0;
            for (int f = 0; f < NumPoints; f++) begin
               d = longint'($signed(s[f*SampleW +: SampleW])) - longint'(sig[r][f]);
               sum += d * d;
            end
            if (sum < best_sum) begin
               best_sum = sum;
               best = r;
            end
         end
         m.idx = bemfnm_pkg::index_type'(best);
         m.cls = motor_code[best];
         due_matches.push_back(m);
         noted++;
      endfunction

      function void check_match(input bemfnm_pkg::index_type got_idx,
                                input bemfnm_pkg::class_type got_cls);
         match_type w;
         if (due_matches.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: index %0d class %0d", got_idx, got_cls);
         end else begin
            w = due_matches.pop_front();
            if (w.idx !== got_idx || w.cls !== got_cls) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected index %0d class %0d, got index %0d class %0d",
                           w.idx, w.cls, got_idx, got_cls);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   bemfnm_pkg::sample_type req_sample_f0 = '0;
   bemfnm_pkg::sample_type req_sample_f1 = '0;
   bemfnm_pkg::sample_type req_sample_f2 = '0;
   bemfnm_pkg::sample_type req_sample_f3 = '0;
   bemfnm_pkg::sample_type req_sample_f4 = '0;
   bemfnm_pkg::sample_type req_sample_f5 = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   bemfnm_pkg::index_type  rsp_best_index;
   bemfnm_pkg::class_type  rsp_class_code;

   match_ledger ledger;
   int          idle_odds = 3;
   bit          calm_tail = 1'b0;

   bemf_signature_nearest_match_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_f0  (req_sample_f0),
      .req_sample_f1  (req_sample_f1),
      .req_sample_f2  (req_sample_f2),
      .req_sample_f3  (req_sample_f3),
      .req_sample_f4  (req_sample_f4),
      .req_sample_f5  (req_sample_f5),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_index (rsp_best_index),
      .rsp_class_code (rsp_class_code)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // overall limit, far above the slowest correct run
   initial begin
      #1000000;
      $display("bemf_signature_nearest_match_unit_test: done, errors");
      $finish;
   end

   // accepted items on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            ledger.note_signature({req_sample_f5, req_sample_f4, req_sample_f3,
                                   req_sample_f2, req_sample_f1, req_sample_f0});
         if (rsp_valid && !rsp_stall)
            ledger.check_match(rsp_best_index, rsp_class_code);
      end
   end

   function automatic logic [NumPoints*SampleW-1:0] pack6(input int a, input int b,
                                                          input int c, input int d,
                                                          input int e, input int f);
      return {12'(f), 12'(e), 12'(d), 12'(c), 12'(b), 12'(a)};
   endfunction

   function automatic int clip12(input int v);
      if (v > 2047)
         return 2047;
      if (v < -2048)
         return -2048;
      return v;
   endfunction

   // random signature: mostly near a reference or between two, some anywhere
   function automatic logic [NumPoints*SampleW-1:0] random_signature();
      logic [NumPoints*SampleW-1:0] s;
      int kind;
      int ra;
      int rb;
      int w;
      int spread;
      int v;
      kind = $urandom_range(0, 9);
      ra = $urandom_range(0, NumRefs-1);
      rb = $urandom_range(0, NumRefs-1);
      w = $urandom_range(0, 16);
      case ($urandom_range(0, 2))
         0: spread = 8;
         1: spread = 60;
         default: spread = 400;
      endcase
      for (int f = 0; f < NumPoints; f++) begin
         if (kind <= 5) begin
            v = ledger.sig[ra][f] + int'($urandom_range(0, 2*spread)) - spread;
         end else if (kind == 6) begin
            v = (ledger.sig[ra][f] * (16 - w) + ledger.sig[rb][f] * w) / 16
                + int'($urandom_range(0, 8)) - 4;
         end else if (kind <= 8) begin
            v = $signed(12'($urandom));
         end else begin
            case ($urandom_range(0, 4))
               0: v = -2048;
               1: v = 2047;
               2: v = 0;
               3: v = -1;
               default: v = $signed(12'($urandom));
            endcase
         end
         s[f*SampleW +: SampleW] = 12'(clip12(v));
      end
      return s;
   endfunction

   // offer one item, with an occasional idle burst ahead of it
   task automatic send_item(input logic [NumPoints*SampleW-1:0] s);
      if (idle_odds != 0 && $urandom_range(0, idle_odds-1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_sample_f5, req_sample_f4, req_sample_f3,
       req_sample_f2, req_sample_f1, req_sample_f0} <= s;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // result side: random stall bursts, one long hold-off to back up the pipeline
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && ledger.noted >= 400) begin
            rsp_stall <= 1'b1;
            repeat (HoldLong) @(posedge clock);
            hold_done = 1'b1;
         end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin
      ledger = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes, each reference exactly, and ties between references
      send_item(pack6(0, 0, 0, 0, 0, 0));
      send_item(pack6(2047, 2047, 2047, 2047, 2047, 2047));
      send_item(pack6(-2048, -2048, -2048, -2048, -2048, -2048));
      send_item(pack6(2047, -2048, 2047, -2048, 2047, -2048));
      send_item(pack6(-2048, 2047, -2048, 2047, -2048, 2047));
      send_item(pack6(-1, -1, -1, -1, -1, -1));
      send_item(pack6(1, 1, 1, 1, 1, 1));
      for (int r = 0; r < NumRefs; r++)
         send_item(pack6(ledger.sig[r][0], ledger.sig[r][1], ledger.sig[r][2],
                         ledger.sig[r][3], ledger.sig[r][4], ledger.sig[r][5]));
      // equal distance to references 0 and 2, both nearer than the rest
      send_item(pack6(1, -81, -114, -248, -312, -501));
      send_item(pack6(1, -81, -251, -248, -312, -260));
      // between references 1 and 3, then between 1 and 4, then mixed extremes
      send_item(pack6(-4, -29, -348, -1238, -1269, -1263));
      send_item(pack6(-5, -38, -822, -1271, -1293, -1291));
      send_item(pack6(2047, 0, -2048, 2047, 0, -2048));
      send_item(pack6(-2048, -2048, -2048, -2048, -2048, 2047));
      drain();

      // random phases, idling varies from phase to phase and stops in the last one
      for (int p = 0; p < NumPhases; p++) begin
         case (p)
            0: idle_odds = 3;
            1: idle_odds = 8;
            2: idle_odds = 2;
            default: idle_odds = 0;
         endcase
         calm_tail = (p == NumPhases - 1);
         for (int i = 0; i < PhaseLen; i++)
            send_item(random_signature());
         drain();
      end

      repeat (10) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("bemf_signature_nearest_match_unit_test: done, clean");
      else
         $display("bemf_signature_nearest_match_unit_test: done, errors");
      $finish;
   end

endmodule
